// ===== rtl/kvte_pkg.sv =====
`timescale 1ns / 1ps

package kvte_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;
  localparam int OCNT_W = 8;
  localparam int DEPTH_DEF = 128;

  localparam logic [MODE_W-1:0] MODE_INSERT      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FIND        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE_KEY  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE_LAST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR       = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             ins;     // shift toward the back, new pair enters cell 0
    logic             del;     // close the gap behind the first selected cell
    logic             by_pos;  // select the last valid cell instead of a key match
    logic [KEY_W-1:0] skey;
  } kvte_ctrl_t;

endpackage

// ===== rtl/kvte_cell.sv =====
`timescale 1ns / 1ps

module kvte_cell
  import kvte_pkg::*;
#(
  parameter int CW  = 8,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  kvte_ctrl_t       ctrl,
  input  logic [CW-1:0]    count,
  input  logic [KEY_W-1:0] prev_key,
  input  logic [VAL_W-1:0] prev_val,
  input  logic [KEY_W-1:0] next_key,
  input  logic [VAL_W-1:0] next_val,
  input  logic             prev_hit,
  input  logic [VAL_W-1:0] prev_hv,
  output logic [KEY_W-1:0] key_o,
  output logic [VAL_W-1:0] val_o,
  output logic             fwd_hit,
  output logic [VAL_W-1:0] fwd_hv
);

  localparam logic [CW-1:0] POS      = CW'(IDX);
  localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             hit_r;   // a selected cell lies in front of this one
  logic [VAL_W-1:0] hv_r;    // value of the first selected cell in front
  logic             valid;
  logic             sel;

  assign valid   = POS < count;
  assign sel     = valid & (ctrl.by_pos ? (POS_NEXT == count) : (key_r == ctrl.skey));
  assign fwd_hit = hit_r | sel;
  assign fwd_hv  = hit_r ? hv_r : val_r;
  assign key_o   = key_r;
  assign val_o   = val_r;

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    if (ctrl.ins) begin
      key_nxt = prev_key;
      val_nxt = prev_val;
    end else if (ctrl.del && fwd_hit) begin
      key_nxt = next_key;
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
    hit_r <= prev_hit;
    hv_r  <= prev_hv;
  end

endmodule

// ===== rtl/key_value_table_engine_core.sv =====
`timescale 1ns / 1ps
// Insert, clear, remove-last on an empty table and unused modes: result strobe in the
// cycle after start is taken, busy stays low, so such items can go back to back.
// Find, remove by key and remove-last: busy through the scan and finish states; the match
// wave crosses the DEPTH cells one per cycle before the result is known.
// Synchronous active-low reset empties the table; the cell contents are not cleared.
// Results are strobed for one cycle; the receiver cannot stall.

module key_value_table_engine_core
  import kvte_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_strobe,
  output logic [STAT_W-1:0] out_status,
  output logic [VAL_W-1:0]  out_found_value,
  output logic [OCNT_W-1:0] out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [SW-1:0] SCAN_LAST = SW'(DEPTH - 2);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [SW-1:0]     scan_r, scan_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [KEY_W-1:0]  skey_r, skey_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              strobe_r, strobe_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [VAL_W-1:0]  fval_r, fval_nxt;
  logic [CW-1:0]     ocnt_r, ocnt_nxt;
  logic [CW+OCNT_W-1:0] ocnt_ext;

  kvte_ctrl_t ctrl;
  logic       ins, del;
  logic       final_hit;
  logic [VAL_W-1:0] final_hv;

  logic [KEY_W-1:0] key_a [DEPTH];
  logic [VAL_W-1:0] val_a [DEPTH];
  logic             hit_a [DEPTH];
  logic [VAL_W-1:0] hv_a  [DEPTH];

  assign ctrl.ins    = ins;
  assign ctrl.del    = del;
  assign ctrl.by_pos = (mode_r == MODE_REMOVE_LAST);
  assign ctrl.skey   = skey_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] pk, nk;
    logic [VAL_W-1:0] pv, nv, ph;
    logic             pht;
    if (i == 0) begin : g_head
      assign pk  = in_key;
      assign pv  = in_value;
      assign pht = 1'b0;
      assign ph  = '0;
    end else begin : g_mid
      assign pk  = key_a[i-1];
      assign pv  = val_a[i-1];
      assign pht = hit_a[i-1];
      assign ph  = hv_a[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nk = key_a[i];
      assign nv = val_a[i];
    end else begin : g_body
      assign nk = key_a[i+1];
      assign nv = val_a[i+1];
    end
    kvte_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count_r),
      .prev_key (pk),
      .prev_val (pv),
      .next_key (nk),
      .next_val (nv),
      .prev_hit (pht),
      .prev_hv  (ph),
      .key_o    (key_a[i]),
      .val_o    (val_a[i]),
      .fwd_hit  (hit_a[i]),
      .fwd_hv   (hv_a[i])
    );
  end

  assign final_hit = hit_a[DEPTH-1];
  assign final_hv  = hv_a[DEPTH-1];

  always_comb begin
    state_nxt  = state_r;
    scan_nxt   = scan_r;
    mode_nxt   = mode_r;
    skey_nxt   = skey_r;
    count_nxt  = count_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    fval_nxt   = fval_r;
    ocnt_nxt   = ocnt_r;
    ins        = 1'b0;
    del        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt   = in_mode;
          skey_nxt   = in_key;
          scan_nxt   = '0;
          status_nxt = STAT_OK;
          fval_nxt   = '0;
          ocnt_nxt   = count_r;
          unique case (in_mode) inside
            MODE_INSERT: begin
              strobe_nxt = 1'b1;
              if (count_r == FULL_CNT) begin
                status_nxt = STAT_FULL;
              end else begin
                ins       = 1'b1;
                count_nxt = count_r + CW'(1);
                ocnt_nxt  = count_r + CW'(1);
              end
            end
            MODE_FIND, MODE_REMOVE_KEY: begin
              state_nxt = S_SCAN;
            end
            MODE_REMOVE_LAST: begin
              if (count_r == '0) begin
                strobe_nxt = 1'b1;
                status_nxt = STAT_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            MODE_CLEAR: begin
              strobe_nxt = 1'b1;
              count_nxt  = '0;
              ocnt_nxt   = '0;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        scan_nxt = scan_r + SW'(1);
        if (scan_r == SCAN_LAST) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        ocnt_nxt   = count_r;
        if (final_hit) begin
          status_nxt = STAT_OK;
          fval_nxt   = final_hv;
          if (mode_r != MODE_FIND) begin
            count_nxt = count_r - CW'(1);
            ocnt_nxt  = count_r - CW'(1);
          end
          del = (mode_r == MODE_REMOVE_KEY);
        end else begin
          status_nxt = STAT_NOT_FOUND;
          fval_nxt   = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
      scan_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
      scan_r   <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    skey_r   <= skey_nxt;
    status_r <= status_nxt;
    fval_r   <= fval_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  assign ocnt_ext        = {{OCNT_W{1'b0}}, ocnt_r};
  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_found_value = fval_r;
  assign out_entry_count = ocnt_ext[OCNT_W-1:0];

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> (state_r == S_IDLE))
    else $error("result strobe while table is busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (strobe_r || state_r == S_SCAN))
    else $error("item taken without result or scan");

  a_last_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && mode_r == MODE_REMOVE_LAST) |-> final_hit)
    else $error("remove-last scan missed the last entry");

endmodule
